[rtl/core/range_image_point_projection_top_assert.svh]
// Assertion macros for the range image projection block.
`ifndef RANGE_IMAGE_POINT_PROJECTION_TOP_ASSERT_SVH
`define RANGE_IMAGE_POINT_PROJECTION_TOP_ASSERT_SVH

`ifndef SYNTH
`define RIP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rip assertion failed");
`define RIP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rip assertion failed");
`else
`define RIP_ASSERT_IMP(lbl, ante, cons)
`define RIP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/rip_pkg.sv]
`default_nettype none
package rip_pkg;

	localparam int GRID_W_DEF       = 256;
	localparam int GRID_H_DEF       = 64;
	localparam int ANGLE_STAGES_DEF = 16;
	localparam int CELL_MAX_W       = 20;
	localparam int REG_W            = 48;

	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [23:0] GND_OFF     = 24'sh800000;
	localparam logic [39:0]        RSQ_INF     = {40{1'b1}};
	localparam logic [19:0]        RANGE_NONE  = {20{1'b1}};

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_NEARER = 3'd1,
		ST_NO_RETURN  = 3'd2,
		ST_RANGE      = 3'd3,
		ST_GROUND     = 3'd4,
		ST_ANGLE      = 3'd5,
		ST_OFF_GRID   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_MIN_RSQ   = 3'd0,
		REG_MAX_RSQ   = 3'd1,
		REG_HHFOV     = 3'd2,
		REG_HVFOV     = 3'd3,
		REG_COL_SCALE = 3'd4,
		REG_ROW_SCALE = 3'd5,
		REG_GND_NORM  = 3'd6,
		REG_GND_THR   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		K_DONE = 2'd0,
		K_PROJ = 2'd1,
		K_READ = 2'd2
	} kind_t;

	typedef struct packed {
		logic [39:0]        min_rsq;
		logic [39:0]        max_rsq;
		logic [17:0]        hhfov;
		logic [17:0]        hvfov;
		logic [31:0]        col_scale;
		logic [31:0]        row_scale;
		logic [47:0]        gnd_normal;
		logic signed [23:0] gnd_thr;
	} cfg_t;

	typedef struct packed {
		kind_t                 kind;
		status_t               status;
		logic [CELL_MAX_W-1:0] cidx;
		logic                  full_range;
		logic [39:0]           rsq;
		logic signed [19:0]    x;
		logic signed [19:0]    y;
		logic signed [19:0]    z;
	} qent_t;

	function automatic logic [15:0] atan_q16(input logic [4:0] i);
		logic [15:0] a;
		case (i)
			5'd0:  a = 16'd51472;
			5'd1:  a = 16'd30386;
			5'd2:  a = 16'd16055;
			5'd3:  a = 16'd8150;
			5'd4:  a = 16'd4091;
			5'd5:  a = 16'd2047;
			5'd6:  a = 16'd1024;
			5'd7:  a = 16'd512;
			5'd8:  a = 16'd256;
			5'd9:  a = 16'd128;
			5'd10: a = 16'd64;
			5'd11: a = 16'd32;
			5'd12: a = 16'd16;
			5'd13: a = 16'd8;
			5'd14: a = 16'd4;
			5'd15: a = 16'd2;
			5'd16: a = 16'd1;
			default: a = 16'd0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

[rtl/core/rip_isqrt.sv]
`default_nettype none
module rip_isqrt
	import rip_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [39:0] radicand,
	output logic             done,
	output logic [19:0]      root
);

	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [39:0] rad_q;
	logic [21:0] rem_q;
	logic [19:0] root_q;
	logic [23:0] rem_sh;
	logic [23:0] trial;
	logic        ge;

	assign rem_sh = {rem_q, rad_q[39:38]};
	assign trial  = {2'd0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd19) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[37:0], 2'b00};
			rem_q  <= ge ? 22'(rem_sh - trial) : rem_sh[21:0];
			root_q <= {root_q[18:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

[rtl/core/rip_cordic.sv]
`default_nettype none
module rip_cordic
	import rip_pkg::*;
#(
	parameter int STAGES = ANGLE_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [20:0] y_in,
	input  wire logic signed [20:0] x_in,
	output logic                    done,
	output logic signed [19:0]      angle
);

	localparam int CNT_W = $clog2(STAGES);

	logic                    run_q;
	logic                    done_q;
	logic [CNT_W-1:0]        i_q;
	logic signed [39:0]      x_q;
	logic signed [39:0]      y_q;
	logic signed [19:0]      ang_q;
	logic signed [39:0]      xs;
	logic signed [39:0]      ys;
	logic signed [39:0]      xsh;
	logic signed [39:0]      ysh;
	logic signed [19:0]      step_ang;
	logic                    zero_in;

	assign xs       = 40'($signed({x_in, 16'd0}));
	assign ys       = 40'($signed({y_in, 16'd0}));
	assign xsh      = x_q >>> i_q;
	assign ysh      = y_q >>> i_q;
	assign step_ang = $signed({4'd0, atan_q16(5'(i_q))});
	assign zero_in  = (x_in == '0) && (y_in == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= !zero_in;
				done_q <= zero_in;
				i_q    <= '0;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == CNT_W'(STAGES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (zero_in) begin
				ang_q <= '0;
			end else if (xs < 0) begin
				if (ys >= 0) begin
					x_q   <= ys;
					y_q   <= -xs;
					ang_q <= HALF_PI_Q16;
				end else begin
					x_q   <= -ys;
					y_q   <= xs;
					ang_q <= -HALF_PI_Q16;
				end
			end else begin
				x_q   <= xs;
				y_q   <= ys;
				ang_q <= '0;
			end
		end else if (run_q) begin
			if (y_q > 0) begin
				x_q   <= x_q + ysh;
				y_q   <= y_q - xsh;
				ang_q <= ang_q + step_ang;
			end else begin
				x_q   <= x_q - ysh;
				y_q   <= y_q + xsh;
				ang_q <= ang_q - step_ang;
			end
		end
	end

	assign done  = done_q;
	assign angle = ang_q;

endmodule
`default_nettype wire

[rtl/core/rip_queue.sv]
`default_nettype none
module rip_queue
	import rip_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t din,
	input  wire logic  pop,
	output qent_t      dout,
	output logic       full,
	output logic       empty
);

	qent_t       slot_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= din;
	end

	assign dout  = slot_q[rp_q];
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;

endmodule
`default_nettype wire

[rtl/core/rip_front.sv]
`default_nettype none
module rip_front
	import rip_pkg::*;
#(
	parameter int GRID_W       = GRID_W_DEF,
	parameter int GRID_H       = GRID_H_DEF,
	parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               start,
	input  wire logic               op,
	input  wire logic signed [19:0] x_mm,
	input  wire logic signed [19:0] y_mm,
	input  wire logic signed [19:0] z_mm,
	input  wire logic               no_return,
	input  wire logic [13:0]        cell_select,
	input  wire logic               q_full,
	output logic                    busy,
	output logic                    push,
	output qent_t                   ent
);

	localparam int CELLS = GRID_W * GRID_H;

	typedef enum logic [10:0] {
		F_IDLE = 11'b000_0000_0001,
		F_SQ   = 11'b000_0000_0010,
		F_CHK  = 11'b000_0000_0100,
		F_YAW  = 11'b000_0000_1000,
		F_RT   = 11'b000_0001_0000,
		F_PIT  = 11'b000_0010_0000,
		F_LIM  = 11'b000_0100_0000,
		F_MUL  = 11'b000_1000_0000,
		F_GRID = 11'b001_0000_0000,
		F_IDX  = 11'b010_0000_0000,
		F_PUSH = 11'b100_0000_0000
	} fstate_t;

	fstate_t            state_q, state_d;
	logic [1:0]         mc_q;
	logic signed [19:0] x_q, y_q, z_q;
	logic [38:0]        xx_q, yy_q, zz_q;
	logic signed [35:0] dx_q, dy_q, dz_q;
	logic [39:0]        rsq_q;
	logic [39:0]        hyp_q;
	logic signed [19:0] yaw_q, pitch_q;
	logic [18:0]        acol_q, arow_q;
	logic [34:0]        p0_q, p1_q, p2_q, p3_q;
	logic [19:0]        u_q, v_q;
	qent_t              ent_q;

	logic               accept;
	logic               sel_big;
	logic signed [39:0] xsq_c, ysq_c, zsq_c;
	logic signed [15:0] nx, ny, nz;
	logic signed [35:0] dx_c, dy_c, dz_c;
	logic [39:0]        rsq_c;
	logic signed [37:0] dot_c, thr_c;
	logic               range_bad, ground_bad;
	logic signed [20:0] hh_s, hv_s, yaw_w, pit_w;
	logic               ang_bad;
	logic [18:0]        mul_a;
	logic [15:0]        mul_b;
	logic [34:0]        prod_c;
	logic [51:0]        u_sum, v_sum;
	logic               grid_bad;
	logic [19:0]        idx_c;

	logic               cor_start, cor_done;
	logic signed [20:0] cor_y, cor_x;
	logic signed [19:0] cor_ang;
	logic               sq_start, sq_done;
	logic [19:0]        sq_root;

	assign accept  = start && state_q == F_IDLE;
	assign sel_big = {18'd0, cell_select} >= 32'(CELLS);

	assign nx = $signed(cfg.gnd_normal[15:0]);
	assign ny = $signed(cfg.gnd_normal[31:16]);
	assign nz = $signed(cfg.gnd_normal[47:32]);

	assign xsq_c = x_q * x_q;
	assign ysq_c = y_q * y_q;
	assign zsq_c = z_q * z_q;
	assign dx_c  = nx * x_q;
	assign dy_c  = ny * y_q;
	assign dz_c  = nz * z_q;

	assign rsq_c      = {1'b0, xx_q} + {1'b0, yy_q} + {1'b0, zz_q};
	assign dot_c      = 38'(dx_q) + 38'(dy_q) + 38'(dz_q);
	assign thr_c      = $signed({cfg.gnd_thr, 14'd0});
	assign range_bad  = rsq_c < cfg.min_rsq || rsq_c > cfg.max_rsq;
	assign ground_bad = cfg.gnd_thr != GND_OFF && dot_c < thr_c;

	assign hh_s    = $signed({3'd0, cfg.hhfov});
	assign hv_s    = $signed({3'd0, cfg.hvfov});
	assign yaw_w   = 21'(yaw_q);
	assign pit_w   = 21'(pitch_q);
	assign ang_bad = yaw_w < -hh_s || yaw_w > hh_s || pit_w < -hv_s || pit_w > hv_s;

	assign mul_a = mc_q[1] ? arow_q : acol_q;
	always_comb begin
		case (mc_q)
			2'd0:    mul_b = cfg.col_scale[15:0];
			2'd1:    mul_b = cfg.col_scale[31:16];
			2'd2:    mul_b = cfg.row_scale[15:0];
			default: mul_b = cfg.row_scale[31:16];
		endcase
	end
	assign prod_c = {16'd0, mul_a} * {19'd0, mul_b};

	assign u_sum = {17'd0, p0_q} + {1'b0, p1_q, 16'd0} + 52'h8000_0000;
	assign v_sum = {17'd0, p2_q} + {1'b0, p3_q, 16'd0} + 52'h8000_0000;

	assign grid_bad = u_q >= 20'(GRID_W) || v_q >= 20'(GRID_H);
	assign idx_c    = 20'(32'(v_q) * GRID_W + 32'(u_q));

	assign cor_start = (state_q == F_CHK && !range_bad && !ground_bad)
		|| (state_q == F_RT && sq_done);
	assign cor_y = (state_q == F_RT) ? 21'(z_q) : 21'(y_q);
	assign cor_x = (state_q == F_RT) ? $signed({1'b0, sq_root}) : 21'(x_q);
	assign sq_start = state_q == F_YAW && cor_done;

	rip_cordic #(
		.STAGES (ANGLE_STAGES)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.y_in   (cor_y),
		.x_in   (cor_x),
		.done   (cor_done),
		.angle  (cor_ang)
	);

	rip_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (hyp_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept) state_d = (op || no_return) ? F_PUSH : F_SQ;
			F_SQ:   state_d = F_CHK;
			F_CHK:  state_d = (range_bad || ground_bad) ? F_PUSH : F_YAW;
			F_YAW:  if (cor_done) state_d = F_RT;
			F_RT:   if (sq_done) state_d = F_PIT;
			F_PIT:  if (cor_done) state_d = F_LIM;
			F_LIM:  state_d = ang_bad ? F_PUSH : F_MUL;
			F_MUL:  if (mc_q == 2'd3) state_d = F_GRID;
			F_GRID: state_d = F_IDX;
			F_IDX:  state_d = F_PUSH;
			F_PUSH: if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_MUL) mc_q <= mc_q + 2'd1;
			else mc_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				x_q <= x_mm;
				y_q <= y_mm;
				z_q <= z_mm;
				ent_q.kind       <= K_DONE;
				ent_q.status     <= ST_NO_RETURN;
				ent_q.cidx       <= '0;
				ent_q.full_range <= 1'b0;
				ent_q.rsq        <= '0;
				ent_q.x          <= x_mm;
				ent_q.y          <= y_mm;
				ent_q.z          <= z_mm;
				if (op) begin
					ent_q.cidx   <= 20'(cell_select);
					ent_q.status <= sel_big ? ST_OFF_GRID : ST_OK;
					ent_q.kind   <= sel_big ? K_DONE : K_READ;
					ent_q.full_range <= sel_big;
				end
			end
			F_SQ: begin
				xx_q <= xsq_c[38:0];
				yy_q <= ysq_c[38:0];
				zz_q <= zsq_c[38:0];
				dx_q <= dx_c;
				dy_q <= dy_c;
				dz_q <= dz_c;
			end
			F_CHK: begin
				rsq_q     <= rsq_c;
				hyp_q     <= {1'b0, xx_q} + {1'b0, yy_q};
				ent_q.rsq <= rsq_c;
				ent_q.status <= range_bad ? ST_RANGE : ST_GROUND;
			end
			F_YAW: if (cor_done) yaw_q <= cor_ang;
			F_RT: begin
			end
			F_PIT: if (cor_done) pitch_q <= cor_ang;
			F_LIM: begin
				acol_q       <= 19'(yaw_w + hh_s);
				arow_q       <= 19'(pit_w + hv_s);
				ent_q.status <= ST_ANGLE;
			end
			F_MUL: begin
				case (mc_q)
					2'd0:    p0_q <= prod_c;
					2'd1:    p1_q <= prod_c;
					2'd2: begin
						p2_q <= prod_c;
						u_q  <= u_sum[51:32];
					end
					default: p3_q <= prod_c;
				endcase
			end
			F_GRID: v_q <= v_sum[51:32];
			F_IDX: begin
				if (grid_bad) begin
					ent_q.status <= ST_OFF_GRID;
				end else begin
					ent_q.kind   <= K_PROJ;
					ent_q.status <= ST_OK;
					ent_q.cidx   <= idx_c;
					ent_q.rsq    <= rsq_q;
				end
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != F_IDLE;
	assign push = state_q == F_PUSH && !q_full;
	assign ent  = ent_q;

endmodule
`default_nettype wire

[rtl/core/rip_back.sv]
`default_nettype none
module rip_back
	import rip_pkg::*;
#(
	parameter int GRID_W = GRID_W_DEF,
	parameter int GRID_H = GRID_H_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire qent_t         q_head,
	output logic               pop,
	output logic               clearing,
	output logic               done,
	output status_t            status,
	output logic [13:0]        cell_index,
	output logic               cell_valid,
	output logic signed [19:0] cell_x_mm,
	output logic signed [19:0] cell_y_mm,
	output logic signed [19:0] cell_z_mm,
	output logic [19:0]        range_mm
);

	localparam int CELLS = GRID_W * GRID_H;
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [3:0] {
		B_CLR  = 4'b0001,
		B_IDLE = 4'b0010,
		B_EVAL = 4'b0100,
		B_SQRT = 4'b1000
	} bstate_t;

	bstate_t      state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [99:0]  mem_q [CELLS];
	logic [99:0]  rdata_q;
	qent_t        cur_q;
	logic [59:0]  pt_q;

	logic         we;
	logic [AW-1:0] waddr;
	logic [99:0]  wdata;
	logic [39:0]  near;
	logic         nearer;
	logic         occupied;
	logic         sq_start, sq_done;
	logic [19:0]  sq_root;

	logic               emit;
	status_t            o_status;
	logic [13:0]        o_cell;
	logic               o_valid;
	logic [59:0]        o_pt;
	logic [19:0]        o_range;

	logic               done_q;
	status_t            status_q;
	logic [13:0]        cell_q;
	logic               valid_q;
	logic [59:0]        pto_q;
	logic [19:0]        range_q;

	assign near     = rdata_q[99:60];
	assign nearer   = cur_q.rsq < near;
	assign occupied = near != RSQ_INF;

	rip_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (near),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_comb begin
		state_d  = state_q;
		we       = 1'b0;
		waddr    = clr_q;
		wdata    = {RSQ_INF, 60'd0};
		pop      = 1'b0;
		sq_start = 1'b0;
		emit     = 1'b0;
		o_status = ST_OK;
		o_cell   = cur_q.cidx[13:0];
		o_valid  = 1'b0;
		o_pt     = '0;
		o_range  = '0;
		unique case (state_q)
			B_CLR: begin
				we = 1'b1;
				if (clr_q == AW'(CELLS - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				pop = !q_empty;
				if (!q_empty) begin
					if (q_head.kind == K_DONE) begin
						emit     = 1'b1;
						o_status = q_head.status;
						o_cell   = q_head.cidx[13:0];
						o_range  = q_head.full_range ? RANGE_NONE : '0;
					end else begin
						state_d = B_EVAL;
					end
				end
			end
			B_EVAL: begin
				waddr = cur_q.cidx[AW-1:0];
				if (cur_q.kind == K_PROJ) begin
					we       = nearer;
					wdata    = {cur_q.rsq, cur_q.x, cur_q.y, cur_q.z};
					emit     = 1'b1;
					o_status = nearer ? ST_OK : ST_NOT_NEARER;
					state_d  = B_IDLE;
				end else begin
					we = 1'b1;
					if (occupied) begin
						sq_start = 1'b1;
						state_d  = B_SQRT;
					end else begin
						emit    = 1'b1;
						o_range = RANGE_NONE;
						state_d = B_IDLE;
					end
				end
			end
			B_SQRT: begin
				if (sq_done) begin
					emit    = 1'b1;
					o_valid = 1'b1;
					o_pt    = pt_q;
					o_range = sq_root;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == B_CLR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[q_head.cidx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_head;
		if (sq_start) pt_q <= rdata_q[59:0];
		if (emit) begin
			status_q <= o_status;
			cell_q   <= o_cell;
			valid_q  <= o_valid;
			pto_q    <= o_pt;
			range_q  <= o_range;
		end
	end

	assign clearing   = state_q == B_CLR;
	assign done       = done_q;
	assign status     = status_q;
	assign cell_index = cell_q;
	assign cell_valid = valid_q;
	assign cell_x_mm  = $signed(pto_q[59:40]);
	assign cell_y_mm  = $signed(pto_q[39:20]);
	assign cell_z_mm  = $signed(pto_q[19:0]);
	assign range_mm   = range_q;

endmodule
`default_nettype wire

[rtl/core/range_image_point_projection_top.sv]
// Projects sensor points onto a spherical range grid that keeps the nearest
// point per cell, and reads and clears cells. Results come with a one-cycle
// done strobe and cannot be held off. After reset a clearing pass writes all
// GRID_W*GRID_H cells with busy high. A projected point keeps the front end
// busy through two passes of one shared CORDIC unit and a 20-step square
// root, a read only through its push state, either plus any wait for a free
// queue slot; behind a two-item queue the cell memory handles a point in its
// idle and evaluate states, and a read of a filled cell also runs a 20-step
// square root. busy is high while the front end works.
`default_nettype none
`include "range_image_point_projection_top_assert.svh"
module range_image_point_projection_top
	import rip_pkg::*;
#(
	parameter int GRID_W       = GRID_W_DEF,
	parameter int GRID_H       = GRID_H_DEF,
	parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [REG_W-1:0]   cfg_data,
	input  wire logic               start,
	input  wire logic               op,
	input  wire logic signed [19:0] x_mm,
	input  wire logic signed [19:0] y_mm,
	input  wire logic signed [19:0] z_mm,
	input  wire logic               no_return,
	input  wire logic [13:0]        cell_select,
	output logic                    busy,
	output logic                    done,
	output logic [2:0]              status,
	output logic [13:0]             cell_index,
	output logic                    cell_valid,
	output logic signed [19:0]      cell_x_mm,
	output logic signed [19:0]      cell_y_mm,
	output logic signed [19:0]      cell_z_mm,
	output logic [19:0]             range_mm
);

	cfg_t    cfg_q;
	logic    front_busy;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;
	logic    clearing;
	qent_t   ent;
	qent_t   q_head;
	status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_rsq    <= '0;
			cfg_q.max_rsq    <= RSQ_INF;
			cfg_q.hhfov      <= 18'd102944;
			cfg_q.hvfov      <= 18'd51472;
			cfg_q.col_scale  <= 32'd5340052;
			cfg_q.row_scale  <= 32'd2671669;
			cfg_q.gnd_normal <= 48'd16384;
			cfg_q.gnd_thr    <= GND_OFF;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_RSQ:   cfg_q.min_rsq    <= cfg_data[39:0];
				REG_MAX_RSQ:   cfg_q.max_rsq    <= cfg_data[39:0];
				REG_HHFOV:     cfg_q.hhfov      <= cfg_data[17:0];
				REG_HVFOV:     cfg_q.hvfov      <= cfg_data[17:0];
				REG_COL_SCALE: cfg_q.col_scale  <= cfg_data[31:0];
				REG_ROW_SCALE: cfg_q.row_scale  <= cfg_data[31:0];
				REG_GND_NORM:  cfg_q.gnd_normal <= cfg_data[47:0];
				REG_GND_THR:   cfg_q.gnd_thr    <= $signed(cfg_data[23:0]);
				default: begin
				end
			endcase
		end
	end

	rip_front #(
		.GRID_W       (GRID_W),
		.GRID_H       (GRID_H),
		.ANGLE_STAGES (ANGLE_STAGES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.start       (start && !clearing),
		.op          (op),
		.x_mm        (x_mm),
		.y_mm        (y_mm),
		.z_mm        (z_mm),
		.no_return   (no_return),
		.cell_select (cell_select),
		.q_full      (q_full),
		.busy        (front_busy),
		.push        (push),
		.ent         (ent)
	);

	rip_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (ent),
		.pop    (pop),
		.dout   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	rip_back #(
		.GRID_W (GRID_W),
		.GRID_H (GRID_H)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.pop        (pop),
		.clearing   (clearing),
		.done       (done),
		.status     (st),
		.cell_index (cell_index),
		.cell_valid (cell_valid),
		.cell_x_mm  (cell_x_mm),
		.cell_y_mm  (cell_y_mm),
		.cell_z_mm  (cell_z_mm),
		.range_mm   (range_mm)
	);

	assign busy   = front_busy || clearing;
	assign status = st;

	`RIP_ASSERT_IMP(a_no_overflow, push, !q_full)
	`RIP_ASSERT_IMP(a_valid_read_ok, done && cell_valid, st == ST_OK)
	`RIP_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`RIP_ASSERT_IMP(a_quiet_clear, clearing, !done && !push)

endmodule
`default_nettype wire
